// ===== hdl/ftbr_pkg.sv =====
package ftbr_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_CHAR  = 3'd1,
    OP_HBAR  = 3'd2,
    OP_VBAR  = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  localparam logic [7:0] FirstCode   = 8'h20;
  localparam logic [7:0] LastCode    = 8'h5A;
  localparam logic [7:0] QuestCode   = 8'h3F;
  localparam logic [7:0] HbarPattern = 8'h3C;
  localparam logic [7:0] FullByte    = 8'hFF;

  // Glyph column lookup: index is code minus FirstCode, column 0..4.
  function automatic logic [7:0] glyph_col(input logic [5:0] idx, input logic [2:0] col);
    logic [39:0] g;
    begin
      unique case (idx)
        6'd0:  g = 40'h0000000000; 6'd1:  g = 40'h00005F0000;
        6'd2:  g = 40'h0007000700; 6'd3:  g = 40'h147F147F14;
        6'd4:  g = 40'h242A7F2A12; 6'd5:  g = 40'h2313086462;
        6'd6:  g = 40'h3649552250; 6'd7:  g = 40'h0005030000;
        6'd8:  g = 40'h001C224100; 6'd9:  g = 40'h0041221C00;
        6'd10: g = 40'h14083E0814; 6'd11: g = 40'h08083E0808;
        6'd12: g = 40'h0050300000; 6'd13: g = 40'h0808080808;
        6'd14: g = 40'h0060600000; 6'd15: g = 40'h2010080402;
        6'd16: g = 40'h3E5149453E; 6'd17: g = 40'h00427F4000;
        6'd18: g = 40'h4261514946; 6'd19: g = 40'h2141454B31;
        6'd20: g = 40'h1814127F10; 6'd21: g = 40'h2745454539;
        6'd22: g = 40'h3C4A494930; 6'd23: g = 40'h0171090503;
        6'd24: g = 40'h3649494936; 6'd25: g = 40'h064949291E;
        6'd26: g = 40'h0036360000; 6'd27: g = 40'h0056360000;
        6'd28: g = 40'h0814224100; 6'd29: g = 40'h1414141414;
        6'd30: g = 40'h0041221408; 6'd31: g = 40'h0201510906;
        6'd32: g = 40'h324979413E; 6'd33: g = 40'h7E1111117E;
        6'd34: g = 40'h7F49494936; 6'd35: g = 40'h3E41414122;
        6'd36: g = 40'h7F4141221C; 6'd37: g = 40'h7F49494941;
        6'd38: g = 40'h7F09090901; 6'd39: g = 40'h3E4149497A;
        6'd40: g = 40'h7F0808087F; 6'd41: g = 40'h00417F4100;
        6'd42: g = 40'h2040413F01; 6'd43: g = 40'h7F08142241;
        6'd44: g = 40'h7F40404040; 6'd45: g = 40'h7F020C027F;
        6'd46: g = 40'h7F0408107F; 6'd47: g = 40'h3E4141413E;
        6'd48: g = 40'h7F09090906; 6'd49: g = 40'h3E4151215E;
        6'd50: g = 40'h7F09192946; 6'd51: g = 40'h4649494931;
        6'd52: g = 40'h01017F0101; 6'd53: g = 40'h3F4040403F;
        6'd54: g = 40'h1F2040201F; 6'd55: g = 40'h3F4038403F;
        6'd56: g = 40'h6314081463; 6'd57: g = 40'h0708700807;
        6'd58: g = 40'h6151494543;
        default: g = 40'h0;
      endcase
      unique case (col)
        3'd0: glyph_col = g[39:32];
        3'd1: glyph_col = g[31:24];
        3'd2: glyph_col = g[23:16];
        3'd3: glyph_col = g[15:8];
        3'd4: glyph_col = g[7:0];
        default: glyph_col = 8'h00;
      endcase
    end
  endfunction

  // Spread four bits to eight, each bit doubled.
  function automatic logic [7:0] dbl4(input logic [3:0] b);
    dbl4 = {b[3], b[3], b[2], b[2], b[1], b[1], b[0], b[0]};
  endfunction

  // Request from the sequencer to the store; the address is 11 bits wide.
  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [10:0] addr;
    logic [7:0]  bits;
    logic        clr;
  } mem_req_t;

endpackage

// ===== hdl/framebuffer_text_bar_renderer_unit.sv =====
// Command-driven renderer into a page-organised 1-bit framebuffer held in one
// single-port RAM of DISPLAY_WIDTH*DISPLAY_HEIGHT/8 bytes. Each byte update is
// a read then a write. After reset, and for every clear command, the RAM is
// swept one byte a cycle while busy_o is high. A character updates its glyph
// columns, doubled in width and height at any scale but 1; a horizontal bar one
// byte per column of its width, a vertical bar one per page, a read one byte.
// Exactly one result per command is strobed on done_o for one cycle; it
// cannot be held off. A new command may be given once busy_o is low.
module framebuffer_text_bar_renderer_unit #(
  parameter int unsigned DISPLAY_WIDTH  = 128,
  parameter int unsigned DISPLAY_HEIGHT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [2:0]        op_i,
  input  logic signed [8:0] x_pos_i,
  input  logic [2:0]        page_i,
  input  logic [7:0]        char_code_i,
  input  logic [1:0]        scale_i,
  input  logic [7:0]        extent_i,
  input  logic [9:0]        read_address_i,
  output logic              done_o,
  output logic [7:0]        read_data_o,
  output logic signed [8:0] next_x_o
);

  localparam int unsigned Pages = DISPLAY_HEIGHT / 8;
  localparam int unsigned Depth = DISPLAY_WIDTH * Pages;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(DISPLAY_WIDTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CLR  = 6'b000010,
    S_RD   = 6'b000100,
    S_WR   = 6'b001000,
    S_RDO  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] op_q;
  logic signed [9:0] x_q;
  logic [3:0] pg_q;
  logic [5:0] gidx_q;
  logic dbl_q;
  logic [8:0] cnt_q, cnt_d, last_q;
  logic [7:0] ext_q;
  logic [9:0] raddr_q;
  logic [AW:0] clr_q, clr_d;
  logic signed [8:0] nx_q;
  logic [7:0] rdata;
  ftbr_pkg::mem_req_t req;

  // Per-step target: column, page and bits to OR; valid when on screen and bits are nonzero.
  logic signed [10:0] col;
  logic [4:0] pg;
  logic [7:0] bits;
  logic [7:0] gc;
  logic [6:0] vtop;
  logic on;

  logic [7:0] code_up, code_fx;
  logic signed [9:0] nx_sum;

  always_comb begin
    code_up = (char_code_i >= 8'h61 && char_code_i <= 8'h7A) ? char_code_i - 8'h20
                                                              : char_code_i;
    code_fx = (code_up < ftbr_pkg::FirstCode || code_up > ftbr_pkg::LastCode)
              ? ftbr_pkg::QuestCode : code_up;
    nx_sum = {x_pos_i[8], x_pos_i} + ((scale_i == 2'd1) ? 10'sd6 : 10'sd12);
  end

  always_comb begin
    col  = 11'sd0;
    pg   = 5'd0;
    bits = 8'h00;
    gc   = 8'h00;
    vtop = 7'd0;
    unique case (op_q)
      ftbr_pkg::OP_CHAR: begin
        if (!dbl_q) begin
          gc   = ftbr_pkg::glyph_col(gidx_q, cnt_q[2:0]);
          col  = 11'(x_q) + 11'(cnt_q);
          pg   = {1'b0, pg_q};
          bits = gc;
        end else begin
          // step = column*4 + sub-column*2 + half
          gc   = ftbr_pkg::glyph_col(gidx_q, cnt_q[4:2]);
          col  = 11'(x_q) + 11'({cnt_q[4:2], 1'b0}) + 11'(cnt_q[1]);
          pg   = {1'b0, pg_q} + 5'(cnt_q[0]);
          bits = cnt_q[0] ? ftbr_pkg::dbl4(gc[7:4]) : ftbr_pkg::dbl4(gc[3:0]);
        end
      end
      ftbr_pkg::OP_HBAR: begin
        col  = 11'(cnt_q);
        pg   = {1'b0, pg_q};
        bits = ftbr_pkg::HbarPattern;
      end
      ftbr_pkg::OP_VBAR: begin
        col  = 11'(x_q);
        pg   = 5'(cnt_q);
        vtop = 7'(DISPLAY_HEIGHT) - 7'(ext_q);
        for (int b = 0; b < 8; b++) begin
          bits[b] = ({cnt_q[3:0], 3'(b)} >= vtop);
        end
      end
      default: ;
    endcase
    on = (col >= 0) && (col < 11'(DISPLAY_WIDTH)) && (pg < 5'(Pages)) && (bits != 8'h00);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    clr_d   = clr_q;
    req     = '0;
    req.addr = 11'(AW'(pg) * AW'(DISPLAY_WIDTH) + AW'(col[CW-1:0]));
    req.bits = rdata | bits;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (op_i)
            ftbr_pkg::OP_CLEAR: begin
              clr_d = '0;
              state_d = S_CLR;
            end
            ftbr_pkg::OP_CHAR, ftbr_pkg::OP_HBAR, ftbr_pkg::OP_VBAR: begin
              cnt_d = '0;
              state_d = S_RD;
            end
            ftbr_pkg::OP_READ: state_d = S_RDO;
            default: state_d = S_DONE;
          endcase
          if (op_i == ftbr_pkg::OP_HBAR && extent_i == 8'd0) state_d = S_DONE;
          if (op_i == ftbr_pkg::OP_VBAR && extent_i == 8'd0) state_d = S_DONE;
        end
      end
      S_CLR: begin
        req.wr  = 1'b1;
        req.clr = 1'b1;
        req.addr = 11'(clr_q[AW-1:0]);
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW+1)'(Depth - 1)) state_d = (op_q == ftbr_pkg::OP_CLEAR) ? S_DONE : S_IDLE;
      end
      S_RD: begin
        req.rd = on;
        state_d = S_WR;
      end
      S_WR: begin
        req.wr = on;
        cnt_d = cnt_q + 1'b1;
        state_d = (cnt_q == last_q) ? S_DONE : S_RD;
      end
      S_RDO: begin
        req.rd = 1'b1;
        req.addr = 11'(raddr_q);
        state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  ftbr_store #(.Depth(Depth), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      cnt_q   <= '0;
      op_q    <= 3'd7;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      if (state_q == S_IDLE && start_i) op_q <= op_i;
    end
  end

  logic [8:0] hw;
  always_comb hw = (extent_i > 8'(DISPLAY_WIDTH - 1) && DISPLAY_WIDTH < 256) ?
                   9'(DISPLAY_WIDTH) : 9'(extent_i);

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      x_q     <= {x_pos_i[8], x_pos_i};
      pg_q    <= {1'b0, page_i};
      gidx_q  <= 6'(code_fx - ftbr_pkg::FirstCode);
      dbl_q   <= (scale_i != 2'd1);
      ext_q   <= (extent_i > 8'(DISPLAY_HEIGHT)) ? 8'(DISPLAY_HEIGHT) : extent_i;
      raddr_q <= read_address_i;
      unique case (op_i)
        ftbr_pkg::OP_CHAR: begin
          last_q <= (scale_i != 2'd1) ? 9'd19 : 9'd4;
          nx_q   <= (nx_sum > 10'sd255) ? 9'sd255 : nx_sum[8:0];
        end
        ftbr_pkg::OP_HBAR: begin
          last_q <= hw - 9'd1;
          nx_q   <= x_pos_i;
        end
        default: begin
          last_q <= 9'(Pages - 1);
          nx_q   <= x_pos_i;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = (state_q == S_DONE);
  assign next_x_o    = nx_q;
  assign read_data_o = (done_o && op_q == ftbr_pkg::OP_READ) ?
                       ((12'(raddr_q) < 12'(Depth)) ? rdata : 8'h00) : 8'h00;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> $past(state_q == S_RD))
    else $error("write without preceding read");
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && op_q != ftbr_pkg::OP_READ) |-> (read_data_o == 8'h00))
    else $error("read data on non-read");

endmodule

// ===== hdl/ftbr_store.sv =====
module ftbr_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AW = 10
) (
  input  logic               clk_i,
  input  ftbr_pkg::mem_req_t req_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[req_i.addr[AW-1:0]] <= req_i.clr ? 8'h00 : req_i.bits;
    end
    if (req_i.rd) begin
      rdata_o <= mem_q[req_i.addr[AW-1:0]];
    end
  end

endmodule

// ===== verif/framebuffer_text_bar_renderer_checker.sv =====
module framebuffer_text_bar_renderer_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [2:0]        op_i,
  input  logic signed [8:0] x_pos_i,
  input  logic [2:0]        page_i,
  input  logic [7:0]        char_code_i,
  input  logic [1:0]        scale_i,
  input  logic [7:0]        extent_i,
  input  logic [9:0]        read_address_i,
  input  logic              done_i,
  input  logic [7:0]        read_data_i,
  input  logic signed [8:0] next_x_i,
  output int                fail_count_o,
  output int                pending_o
);
  import ftbr_pkg::*;

  localparam int Width = 128;
  localparam int Pages = 8;

  typedef struct {
    logic [7:0] read_data;
    logic [8:0] next_x;
  } frame_result_t;

  logic [7:0] shadow_frame [Width*Pages];
  frame_result_t expected_results[$];

  function automatic logic [7:0] glyph_byte(input int idx, input int col);
    logic [7:0] font [59*5];
    font = '{
      8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,
      8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,
      8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
      8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00,
      8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00,
      8'h14,8'h08,8'h3E,8'h08,8'h14, 8'h08,8'h08,8'h3E,8'h08,8'h08,
      8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
      8'h00,8'h60,8'h60,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
      8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
      8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31,
      8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
      8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
      8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E,
      8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h56,8'h36,8'h00,8'h00,
      8'h08,8'h14,8'h22,8'h41,8'h00, 8'h14,8'h14,8'h14,8'h14,8'h14,
      8'h00,8'h41,8'h22,8'h14,8'h08, 8'h02,8'h01,8'h51,8'h09,8'h06,
      8'h32,8'h49,8'h79,8'h41,8'h3E, 8'h7E,8'h11,8'h11,8'h11,8'h7E,
      8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
      8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41,
      8'h7F,8'h09,8'h09,8'h09,8'h01, 8'h3E,8'h41,8'h49,8'h49,8'h7A,
      8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
      8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41,
      8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h7F,8'h02,8'h0C,8'h02,8'h7F,
      8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
      8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E,
      8'h7F,8'h09,8'h19,8'h29,8'h46, 8'h46,8'h49,8'h49,8'h49,8'h31,
      8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
      8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h3F,8'h40,8'h38,8'h40,8'h3F,
      8'h63,8'h14,8'h08,8'h14,8'h63, 8'h07,8'h08,8'h70,8'h08,8'h07,
      8'h61,8'h51,8'h49,8'h45,8'h43};
    return font[idx*5 + col];
  endfunction

  function automatic void merge_byte(input int col, input int pg, input logic [7:0] bits);
    if (col >= 0 && col < Width && pg >= 0 && pg < Pages)
      shadow_frame[pg*Width + col] |= bits;
  endfunction

  function automatic frame_result_t render_command(input logic [2:0] op, input int x,
                                                   input int pg, input logic [7:0] code,
                                                   input logic [1:0] scale, input int ext,
                                                   input int addr);
    frame_result_t r;
    logic [7:0] c;
    logic [7:0] bits;
    logic [15:0] wide;
    int col;
    int top;
    r.read_data = 8'h00;
    r.next_x = x[8:0];
    case (op)
      OP_CLEAR: begin
        foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      end
      OP_CHAR: begin
        c = code;
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
        if (c < FirstCode || c > LastCode) c = QuestCode;
        col = x;
        for (int k = 0; k < 5; k++) begin
          bits = glyph_byte(c - FirstCode, k);
          if (scale == 2'd1) begin
            merge_byte(col, pg, bits);
            col++;
          end else begin
            for (int b = 0; b < 8; b++) begin
              wide[2*b] = bits[b];
              wide[2*b+1] = bits[b];
            end
            merge_byte(col, pg, wide[7:0]);
            merge_byte(col, pg + 1, wide[15:8]);
            merge_byte(col + 1, pg, wide[7:0]);
            merge_byte(col + 1, pg + 1, wide[15:8]);
            col += 2;
          end
        end
        col += (scale == 2'd1) ? 1 : 2;
        if (col > 255) col = 255;
        r.next_x = col[8:0];
      end
      OP_HBAR: begin
        if (ext > Width) ext = Width;
        for (int i = 0; i < ext; i++) merge_byte(i, pg, HbarPattern);
      end
      OP_VBAR: begin
        if (ext > Pages*8) ext = Pages*8;
        top = Pages*8 - ext;
        for (int p = 0; p < Pages; p++) begin
          bits = 8'h00;
          for (int b = 0; b < 8; b++)
            if (p*8 + b >= top) bits[b] = 1'b1;
          if (bits != 8'h00) merge_byte(x, p, bits);
        end
      end
      OP_READ: begin
        if (addr < Width*Pages) r.read_data = shadow_frame[addr];
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      expected_results.delete();
      fail_count_o <= 0;
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("Result strobed with no command outstanding.");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (read_data_i !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, read_data_i);
            fail_count_o <= fail_count_o + 1;
          end
          if (next_x_i !== want.next_x) begin
            $error("next_x: expected %0d, got %0d", $signed(want.next_x), next_x_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i)
        expected_results.push_back(render_command(op_i, int'(x_pos_i), int'(page_i),
                                                  char_code_i, scale_i, int'(extent_i),
                                                  int'(read_address_i)));
    end
  end
endmodule

// ===== verif/tb_framebuffer_text_bar_renderer_unit.sv =====
module tb_framebuffer_text_bar_renderer_unit;
  import ftbr_pkg::*;

  localparam int CycleLimit = 600000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [2:0]        op_i = OP_READ;
  logic signed [8:0] x_pos_i = '0;
  logic [2:0]        page_i = '0;
  logic [7:0]        char_code_i = '0;
  logic [1:0]        scale_i = 2'd1;
  logic [7:0]        extent_i = '0;
  logic [9:0]        read_address_i = '0;
  logic              done_o;
  logic [7:0]        read_data_o;
  logic signed [8:0] next_x_o;
  int                fail_count;
  int                pending;
  int                cycle_count = 0;
  int                idle_pct = 0;

  always #2 clk_i = ~clk_i;

  framebuffer_text_bar_renderer_unit DUT (.*);

  framebuffer_text_bar_renderer_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .op_i, .x_pos_i, .page_i, .char_code_i,
    .scale_i, .extent_i, .read_address_i, .done_i(done_o), .read_data_i(read_data_o),
    .next_x_i(next_x_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Holds start until busy_o is sampled low on the rising clock, with random gaps in front of it.
  // Start stays high on return; a gap or the end of the run lowers it.
  task automatic issue_item(input logic [2:0] op, input logic [8:0] x, input logic [2:0] pg,
                            input logic [7:0] code, input logic [1:0] scale,
                            input logic [7:0] ext, input logic [9:0] addr);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    end
    start_i <= 1'b1;
    op_i <= op;
    x_pos_i <= x;
    page_i <= pg;
    char_code_i <= code;
    scale_i <= scale;
    extent_i <= ext;
    read_address_i <= addr;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic issue_random_item();
    logic [2:0] op;
    logic [8:0] x;
    int sel;
    sel = $urandom_range(99);
    if (sel < 2) op = OP_CLEAR;
    else if (sel < 40) op = OP_CHAR;
    else if (sel < 50) op = OP_HBAR;
    else if (sel < 60) op = OP_VBAR;
    else if (sel < 95) op = OP_READ;
    else op = 3'($urandom_range(7, 5));
    // Mostly on-screen positions, so that drawing lands where reads can see it.
    x = ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(127));
    issue_item(op, x, 3'($urandom), 8'($urandom),
               ($urandom_range(3) == 0) ? 2'($urandom) : 2'($urandom_range(2, 1)),
               8'($urandom), ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(1023)));
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    issue_item(OP_CHAR, 9'd0, 3'd0, 8'h41, 2'd1, 8'd0, 10'd0);
    issue_item(OP_READ, 9'd0, 3'd0, 8'd0, 2'd1, 8'd0, 10'd0);
    issue_item(OP_CHAR, 9'd250, 3'd7, 8'h7A, 2'd2, 8'd0, 10'd0);
    issue_item(OP_CHAR, 9'h100, 3'd6, 8'hFF, 2'd0, 8'd0, 10'd0);
    issue_item(OP_CHAR, 9'h1FE, 3'd1, 8'h20, 2'd3, 8'd0, 10'd0);
    issue_item(OP_CHAR, 9'd124, 3'd2, 8'h5A, 2'd1, 8'd0, 10'd0);
    issue_item(OP_READ, 9'd0, 3'd0, 8'd0, 2'd1, 8'd0, 10'd383);
    issue_item(OP_CHAR, 9'd10, 3'd3, 8'h61, 2'd2, 8'd0, 10'd0);
    issue_item(OP_READ, 9'd0, 3'd0, 8'd0, 2'd1, 8'd0, 10'd394);
    issue_item(OP_HBAR, 9'h1FF, 3'd5, 8'd0, 2'd1, 8'd0, 10'd0);
    issue_item(OP_HBAR, 9'd0, 3'd5, 8'd255, 2'd1, 8'd255, 10'd0);
    issue_item(OP_READ, 9'd0, 3'd0, 8'd0, 2'd1, 8'd0, 10'd767);
    issue_item(OP_VBAR, 9'd127, 3'd0, 8'd0, 2'd1, 8'd255, 10'd0);
    issue_item(OP_VBAR, 9'd60, 3'd0, 8'd0, 2'd1, 8'd3, 10'd0);
    issue_item(OP_VBAR, 9'd128, 3'd0, 8'd0, 2'd1, 8'd0, 10'd0);
    issue_item(OP_READ, 9'd0, 3'd0, 8'd0, 2'd1, 8'd0, 10'd1020);
    issue_item(OP_READ, 9'd0, 3'd0, 8'd0, 2'd1, 8'd0, 10'd127);
    issue_item(3'd5, 9'd77, 3'd0, 8'd0, 2'd1, 8'd0, 10'd0);
    issue_item(3'd7, 9'h155, 3'd7, 8'hAA, 2'd1, 8'hAA, 10'h2AA);
    issue_item(OP_CLEAR, 9'd3, 3'd0, 8'd0, 2'd1, 8'd0, 10'd0);
    issue_item(OP_READ, 9'd0, 3'd0, 8'd0, 2'd1, 8'd0, 10'd0);
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 14 : (phase == 1) ? 45 : 0;
      for (int n = 0; n < 660; n++) issue_random_item();
    end
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
